// ===== rtl/region_address_translation_table_unit_assert.svh =====
// Assertion macros used by the translation table top level.
`ifndef REGION_ADDRESS_TRANSLATION_TABLE_UNIT_ASSERT_SVH
`define REGION_ADDRESS_TRANSLATION_TABLE_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RATT_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RATT_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/ratt_pkg.sv =====
// Package with shared types and codes of the translation table.
package ratt_pkg;
  localparam int TableDepth = 128;
  localparam int AddrBits = 32;
  localparam int LenBits = 31;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_V2P = 2'd2;
  localparam logic [1:0] REQ_P2V = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Request as handed from the front part to the back part.
  typedef struct packed {
    logic [1:0] req_type;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [30:0] region_bytes;
  } req_t;

  // Result as handed to the output stage.
  typedef struct packed {
    logic [1:0] status;
    logic [31:0] out_addr;
    logic [30:0] out_size;
  } res_t;
endpackage

// ===== rtl/ratt_queue.sv =====
// Two-entry request queue between the front and back parts.
module ratt_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  ratt_pkg::req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output ratt_pkg::req_t out_req
);
  import ratt_pkg::*;
  req_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_req = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req;
  end
endmodule

// ===== rtl/ratt_engine.sv =====
// Back part: table memories and the sequential search engine.
module ratt_engine #(
  parameter int TABLE_DEPTH = ratt_pkg::TableDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  output logic req_ready,
  input  ratt_pkg::req_t req,
  output logic res_valid,
  input  logic res_ready,
  output ratt_pkg::res_t res
);
  import ratt_pkg::*;
  localparam int ADDR_BITS = AddrBits;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CMP = 3'd2,
    S_MOVE = 3'd3, S_WMOV = 3'd4, S_OUT = 3'd5;

  logic [ADDR_BITS-1:0] vmem [TABLE_DEPTH];
  logic [ADDR_BITS-1:0] pmem [TABLE_DEPTH];
  logic [LenBits-1:0] lmem [TABLE_DEPTH];

  logic [2:0] state_r;
  logic [CW-1:0] count_r, idx_r;
  logic [IW-1:0] rd_addr, hit_r;
  logic [ADDR_BITS-1:0] rv_r, rp_r;
  logic [LenBits-1:0] rl_r;
  req_t cur_r;
  res_t res_r;
  logic res_valid_r;
  logic we;
  logic [IW-1:0] wa;
  logic [ADDR_BITS-1:0] wv, wp;
  logic [LenBits-1:0] wl;
  logic [ADDR_BITS-1:0] key, kst, ost, delta;
  logic [ADDR_BITS:0] sub;
  logic match;

  assign req_ready = (state_r == S_IDLE) && !res_valid_r;
  assign res_valid = res_valid_r;
  assign res = res_r;

  // Compare the key against the entry just read.
  always_comb begin
    key = (cur_r.req_type == REQ_P2V) ? cur_r.phys_addr[ADDR_BITS-1:0]
                                      : cur_r.virt_addr[ADDR_BITS-1:0];
    kst = (cur_r.req_type == REQ_P2V) ? rp_r : rv_r;
    ost = (cur_r.req_type == REQ_P2V) ? rv_r : rp_r;
    sub = {1'b0, key} - {1'b0, kst};
    delta = sub[ADDR_BITS-1:0];
    match = !sub[ADDR_BITS] && ({1'b0, delta} < {{(ADDR_BITS+1-LenBits){1'b0}}, rl_r});
  end

  // Read address selection: scan index or last entry.
  always_comb begin
    rd_addr = (state_r == S_MOVE) ? IW'(count_r - CW'(1)) : idx_r[IW-1:0];
  end

  // Table memories with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      vmem[wa] <= wv;
      pmem[wa] <= wp;
      lmem[wa] <= wl;
    end
    rv_r <= vmem[rd_addr];
    rp_r <= pmem[rd_addr];
    rl_r <= lmem[rd_addr];
  end

  // Write port control.
  always_comb begin
    we = 1'b0;
    wa = hit_r;
    wv = rv_r;
    wp = rp_r;
    wl = rl_r;
    if (state_r == S_IDLE && req_valid && req_ready && req.req_type == REQ_INSERT
        && count_r != CW'(TABLE_DEPTH)) begin
      we = 1'b1;
      wa = count_r[IW-1:0];
      wv = req.virt_addr[ADDR_BITS-1:0];
      wp = req.phys_addr[ADDR_BITS-1:0];
      wl = req.region_bytes;
    end else if (state_r == S_WMOV) begin
      we = 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      res_valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            cur_r <= req;
            idx_r <= '0;
            if (req.req_type == REQ_INSERT) begin
              res_valid_r <= 1'b1;
              res_r.out_addr <= '0;
              res_r.out_size <= '0;
              if (count_r == CW'(TABLE_DEPTH)) res_r.status <= ST_FULL;
              else begin
                res_r.status <= ST_OK;
                count_r <= count_r + CW'(1);
              end
            end else state_r <= S_RD;
          end
        end
        S_RD: begin
          if (idx_r == count_r) begin
            res_r.status <= ST_MISS;
            res_r.out_addr <= '1;
            res_r.out_size <= '0;
            state_r <= S_OUT;
          end else state_r <= S_CMP;
        end
        S_CMP: begin
          if (match) begin
            hit_r <= idx_r[IW-1:0];
            res_r.status <= ST_OK;
            if (cur_r.req_type == REQ_REMOVE) begin
              res_r.out_addr <= '0;
              res_r.out_size <= '0;
              state_r <= S_MOVE;
            end else begin
              res_r.out_addr <= 32'(ost + delta);
              res_r.out_size <= (cur_r.req_type == REQ_V2P) ? rl_r : '0;
              state_r <= S_OUT;
            end
          end else begin
            idx_r <= idx_r + CW'(1);
            state_r <= S_RD;
          end
        end
        S_MOVE: state_r <= S_WMOV;
        S_WMOV: begin
          count_r <= count_r - CW'(1);
          state_r <= S_OUT;
        end
        S_OUT: begin
          res_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/region_address_translation_table_unit.sv =====
// Top level of the region address translation table.
// Usage:
//   Requests arrive on the in_ channel: in_tuser carries the request type,
//   in_tdata the virtual start or address, physical start or address and
//   region size. Every request yields exactly one result on the out_
//   channel: out_tuser holds the status, out_tdata the address and size.
//   A request first enters a two-entry queue, then the search engine.
//   An insert is answered straight from the idle state. A lookup or remove
//   scans the table entry by entry through the registered memory read port,
//   with a read state and a compare state per entry; a remove then moves
//   the last entry into the freed slot.
//   The queue keeps taking requests while the engine is busy or while a
//   result waits for the receiver; when the receiver stalls, the engine
//   holds its result and the queue fills, then in_tready drops.
//   Reset empties the table (entry count zero) and the queue; no memory
//   clearing pass is needed.
module region_address_translation_table_unit #(
  parameter int TABLE_DEPTH = ratt_pkg::TableDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [95:0] in_tdata,  // virt_addr, phys_addr, region_bytes
  input  logic [1:0] in_tuser,   // req_type
  output logic out_tvalid,
  input  logic out_tready,
  output logic [63:0] out_tdata, // out_addr, out_size
  output logic [1:0] out_tuser   // status
);
  import ratt_pkg::*;
  `include "region_address_translation_table_unit_assert.svh"

  req_t in_req, q_req;
  res_t res;
  logic q_valid, q_ready;
  logic out_miss, out_full, out_stall;

  // Gather the input fields.
  always_comb begin
    in_req.req_type = in_tuser;
    in_req.virt_addr = in_tdata[31:0];
    in_req.phys_addr = in_tdata[63:32];
    in_req.region_bytes = in_tdata[94:64];
  end

  ratt_queue u_queue (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_req(in_req),
    .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
  );

  ratt_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk, .rst_n,
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {1'b0, res.out_size, res.out_addr};
  assign out_tuser = res.status;

  // Conditions watched by the assertions.
  assign out_miss = out_tvalid && out_tuser == ST_MISS;
  assign out_full = out_tvalid && out_tuser == ST_FULL;
  assign out_stall = out_tvalid && !out_tready;

  // A miss always reports all ones; a full table reports no address.
  `RATT_ASSERT_IMPL(a_miss_addr, clk, rst_n, out_miss, out_tdata[31:0] == 32'hFFFFFFFF)
  `RATT_ASSERT_IMPL(a_full_zero, clk, rst_n, out_full, out_tdata == 64'd0)
  // A held result stays in place while the receiver stalls.
  `RATT_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))
endmodule
